// ===== hw/rtl/grid_block_binner_core_defines.svh =====
// Assertion macros shared by the grid block binner RTL.
`ifndef GRID_BLOCK_BINNER_CORE_DEFINES_SVH
`define GRID_BLOCK_BINNER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold in every cycle out of reset.
`define GBB_ASSERT_ALW(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/gbb_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the grid block binner.
`default_nettype none

package gbb_pkg;

  // Field widths of the request and result beats
  localparam int IDX_W      = 14;
  localparam int PIX_W      = 9;
  localparam int OFS_W      = 6;
  localparam int ID_W       = 6;
  localparam int SLOT_OUT_W = 5;
  localparam int CFG_IDX_W  = 1;

  // Magnitude bits of a coordinate once the offset and pad are taken off
  localparam int POS_W = 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESH_OFFSET_X = 1'b0,
    REG_MESH_OFFSET_Y = 1'b1
  } cfg_reg_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BINNED   = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DRAINED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div;
    logic loc;
    logic frd;
    logic bin_commit;
    logic drain_start;
    logic drain_emit;
    logic empty_emit;
  } gbb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic drain_empty;
    logic drain_last;
  } gbb_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbb_axis.sv =====
// One axis of the locator: reciprocal divide by the block width and core window test.
`default_nettype none

module gbb_axis
  import gbb_pkg::*;
#(
  parameter int BLOCK_WIDTH    = 42,
  parameter int CORE_START     = 16,
  parameter int CORE_WIDTH     = 10,
  parameter int BLOCKS_PER_DIM = 8
) (
  input  logic                              clk,
  input  logic                              ld,
  input  logic                              div,
  input  logic                              loc,
  input  logic [POS_W:0]                    pos_in,
  output logic                              hit,
  output logic [$clog2(BLOCKS_PER_DIM)-1:0] coord
);

  localparam int BC_W        = $clog2(BLOCKS_PER_DIM);
  // Reciprocal scaled so the estimate is the true quotient or one below it
  localparam int RECIP_SHIFT = POS_W + $clog2(BLOCK_WIDTH);
  localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / BLOCK_WIDTH;

  localparam logic [POS_W:0]   RECIP_K = (POS_W+1)'(RECIP_MUL);
  localparam logic [POS_W-1:0] BW_K    = POS_W'(BLOCK_WIDTH);
  localparam logic [POS_W-1:0] BPD_K   = POS_W'(BLOCKS_PER_DIM);
  localparam logic [POS_W-1:0] CS_K    = POS_W'(CORE_START);
  localparam logic [POS_W-1:0] CE_K    = POS_W'(CORE_START + CORE_WIDTH);

  logic [POS_W:0]     pos_r;
  logic [POS_W-1:0]   quot_r;
  logic [2*POS_W:0]   prod;
  logic [POS_W-1:0]   qbw;
  logic [POS_W-1:0]   rem_raw;
  logic [POS_W-1:0]   rem_fix;
  logic [POS_W-1:0]   quot_fix;
  logic               over;
  logic               hit_r;
  logic [BC_W-1:0]    coord_r;

  // Quotient estimate from the reciprocal product
  assign prod = pos_r[POS_W-1:0] * RECIP_K;

  // Remainder, with one correction step when the estimate fell short
  assign qbw      = quot_r * BW_K;
  assign rem_raw  = pos_r[POS_W-1:0] - qbw;
  assign over     = (rem_raw >= BW_K);
  assign rem_fix  = over ? (rem_raw - BW_K) : rem_raw;
  assign quot_fix = quot_r + POS_W'(over);

  // Position, estimate and located block, each loaded on its own command
  always_ff @(posedge clk) begin
    if (ld) begin
      pos_r <= pos_in;
    end
    if (div) begin
      quot_r <= POS_W'(prod >> RECIP_SHIFT);
    end
    if (loc) begin
      hit_r   <= !pos_r[POS_W] && (quot_fix < BPD_K) &&
                 (rem_fix >= CS_K) && (rem_fix < CE_K);
      coord_r <= quot_fix[BC_W-1:0];
    end
  end

  assign hit   = hit_r;
  assign coord = coord_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_datapath.sv =====
// Datapath of the binner: offsets, locators, bucket count and entry memories, result register.
`default_nettype none

module gbb_datapath
  import gbb_pkg::*;
#(
  parameter int BLOCK_WIDTH    = 42,
  parameter int CORE_START     = 16,
  parameter int CORE_WIDTH     = 10,
  parameter int BLOCKS_PER_DIM = 8,
  parameter int BUCKET_DEPTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [OFS_W-1:0]      cfg_wdata,
  input  logic                  in_req_type,
  input  logic [IDX_W-1:0]      in_object_index,
  input  logic [PIX_W-1:0]      in_x_pixel,
  input  logic [PIX_W-1:0]      in_y_pixel,
  input  logic [ID_W-1:0]       in_drain_block,
  input  gbb_cmd_t              cmd,
  output gbb_stat_t             stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [ID_W-1:0]       out_blk_num,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [IDX_W-1:0]      out_found_index,
  output logic                  out_last
);

  localparam int NUM_BLOCKS = BLOCKS_PER_DIM * BLOCKS_PER_DIM;
  localparam int BC_W       = $clog2(BLOCKS_PER_DIM);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int SLOT_W     = $clog2(BUCKET_DEPTH);
  localparam int FILL_W     = $clog2(BUCKET_DEPTH + 1);

  localparam logic [POS_W:0]    HALF_BW = (POS_W+1)'(BLOCK_WIDTH / 2);
  localparam logic [FILL_W-1:0] DEPTH_K = FILL_W'(BUCKET_DEPTH);

  // Configuration and request registers
  logic signed [OFS_W-1:0] ofs_x_r;
  logic signed [OFS_W-1:0] ofs_y_r;
  logic                    req_r;
  logic [IDX_W-1:0]        obj_r;
  logic [ID_W-1:0]         db_r;
  logic                    db_ok_r;

  // Locator
  logic [POS_W:0]          pos_x;
  logic [POS_W:0]          pos_y;
  logic                    hit_x;
  logic                    hit_y;
  logic [BC_W-1:0]         coord_x;
  logic [BC_W-1:0]         coord_y;
  logic [BLK_W-1:0]        blk_calc;
  logic [BLK_W-1:0]        blk_r;
  logic                    bin_hit_r;
  logic [BLK_W-1:0]        dblk;

  // Bucket counts with per-block valid bits, and bucket entries
  logic [FILL_W-1:0]       fill_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]   fill_vld_r;
  logic [BLK_W-1:0]        fill_addr;
  logic [FILL_W-1:0]       fill_q_r;
  logic                    fill_qv_r;
  logic [FILL_W-1:0]       fill_cur;
  logic                    full;
  logic                    bin_write;
  logic [IDX_W-1:0]        ent_mem [NUM_BLOCKS][BUCKET_DEPTH];
  logic [IDX_W-1:0]        ent_q_r;

  // Drain walk
  logic [FILL_W-1:0]       n_r;
  logic [FILL_W-1:0]       k_r;
  logic                    drain_last;

  // Result register
  logic                    emit;
  logic                    out_valid_r;
  status_t                 out_status_r;
  status_t                 out_status_nxt;
  logic [ID_W-1:0]         out_blk_num_r;
  logic [ID_W-1:0]         out_blk_num_nxt;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  logic [SLOT_OUT_W-1:0]   out_slot_nxt;
  logic [IDX_W-1:0]        out_found_index_r;
  logic [IDX_W-1:0]        out_found_index_nxt;
  logic                    out_last_r;
  logic                    out_last_nxt;

  // Mesh offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= '0;
      ofs_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MESH_OFFSET_X: ofs_x_r <= cfg_wdata;
        REG_MESH_OFFSET_Y: ofs_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      obj_r   <= in_object_index;
      db_r    <= in_drain_block;
      db_ok_r <= (int'(in_drain_block) < NUM_BLOCKS);
    end
  end

  // Coordinates less the mesh offset and the half-block pad
  assign pos_x = (POS_W+1)'(in_x_pixel) - (POS_W+1)'(ofs_x_r) - HALF_BW;
  assign pos_y = (POS_W+1)'(in_y_pixel) - (POS_W+1)'(ofs_y_r) - HALF_BW;

  gbb_axis #(
    .BLOCK_WIDTH    (BLOCK_WIDTH),
    .CORE_START     (CORE_START),
    .CORE_WIDTH     (CORE_WIDTH),
    .BLOCKS_PER_DIM (BLOCKS_PER_DIM)
  ) u_axis_x (
    .clk    (clk),
    .ld     (cmd.load),
    .div    (cmd.div),
    .loc    (cmd.loc),
    .pos_in (pos_x),
    .hit    (hit_x),
    .coord  (coord_x)
  );

  gbb_axis #(
    .BLOCK_WIDTH    (BLOCK_WIDTH),
    .CORE_START     (CORE_START),
    .CORE_WIDTH     (CORE_WIDTH),
    .BLOCKS_PER_DIM (BLOCKS_PER_DIM)
  ) u_axis_y (
    .clk    (clk),
    .ld     (cmd.load),
    .div    (cmd.div),
    .loc    (cmd.loc),
    .pos_in (pos_y),
    .hit    (hit_y),
    .coord  (coord_y)
  );

  // Block number: column from x times blocks per dimension, plus row from y
  assign blk_calc = BLK_W'(coord_x * BLOCKS_PER_DIM) + BLK_W'(coord_y);
  assign dblk     = BLK_W'(db_r);

  always_ff @(posedge clk) begin
    if (cmd.frd) begin
      blk_r     <= blk_calc;
      bin_hit_r <= hit_x & hit_y;
    end
  end

  // Bucket count memory, read every cycle at the block of the current request
  assign fill_addr = req_r ? dblk : blk_calc;

  always_ff @(posedge clk) begin
    fill_q_r  <= fill_mem[fill_addr];
    fill_qv_r <= fill_vld_r[fill_addr];
    if (bin_write) begin
      fill_mem[blk_r] <= fill_cur + FILL_W'(1);
    end
  end

  // A block whose valid bit is clear holds no entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r <= '0;
    end else begin
      if (bin_write) begin
        fill_vld_r[blk_r] <= 1'b1;
      end
      if (cmd.drain_start) begin
        fill_vld_r[dblk] <= 1'b0;
      end
    end
  end

  assign fill_cur  = fill_qv_r ? fill_q_r : '0;
  assign full      = (fill_cur >= DEPTH_K);
  assign bin_write = cmd.bin_commit && bin_hit_r && !full;

  // Bucket entry memory
  always_ff @(posedge clk) begin
    ent_q_r <= ent_mem[dblk][k_r[SLOT_W-1:0]];
    if (bin_write) begin
      ent_mem[blk_r][fill_cur[SLOT_W-1:0]] <= obj_r;
    end
  end

  // Drain walk over the bucket in insertion order
  always_ff @(posedge clk) begin
    if (cmd.drain_start) begin
      n_r <= fill_cur;
      k_r <= '0;
    end else if (cmd.drain_emit) begin
      k_r <= k_r + FILL_W'(1);
    end
  end

  assign drain_last = ((k_r + FILL_W'(1)) == n_r);

  // Next result beat
  assign emit = cmd.bin_commit | cmd.drain_emit | cmd.empty_emit;

  always_comb begin
    out_status_nxt      = ST_EMPTY;
    out_blk_num_nxt     = db_r;
    out_slot_nxt        = '0;
    out_found_index_nxt = '0;
    out_last_nxt        = 1'b1;
    if (cmd.bin_commit) begin
      out_found_index_nxt = obj_r;
      if (!bin_hit_r) begin
        out_status_nxt  = ST_OUTSIDE;
        out_blk_num_nxt = '0;
      end else if (full) begin
        out_status_nxt  = ST_FULL;
        out_blk_num_nxt = ID_W'(blk_r);
      end else begin
        out_status_nxt  = ST_BINNED;
        out_blk_num_nxt = ID_W'(blk_r);
        out_slot_nxt    = SLOT_OUT_W'(fill_cur);
      end
    end else if (cmd.drain_emit) begin
      out_status_nxt      = ST_DRAINED;
      out_slot_nxt        = SLOT_OUT_W'(k_r);
      out_found_index_nxt = ent_q_r;
      out_last_nxt        = drain_last;
    end
  end

  // Output register: holds a beat until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r      <= out_status_nxt;
      out_blk_num_r     <= out_blk_num_nxt;
      out_slot_r        <= out_slot_nxt;
      out_found_index_r <= out_found_index_nxt;
      out_last_r        <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_blk_num     = out_blk_num_r;
  assign out_slot        = out_slot_r;
  assign out_found_index = out_found_index_r;
  assign out_last        = out_last_r;

  // Status back to the controller
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.drain_empty = !db_ok_r || (fill_cur == '0);
  assign stat.drain_last  = drain_last;

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_ctrl.sv =====
// Controller state machine that sequences bin and drain requests.
`default_nettype none

module gbb_ctrl
  import gbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  input  gbb_stat_t stat,
  output gbb_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_DIV  = 9'b0_0000_0010,
    S_LOC  = 9'b0_0000_0100,
    S_FRD  = 9'b0_0000_1000,
    S_BUPD = 9'b0_0001_0000,
    S_DRD  = 9'b0_0010_0000,
    S_DCHK = 9'b0_0100_0000,
    S_ERD  = 9'b0_1000_0000,
    S_EOUT = 9'b1_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_req_type ? S_DRD : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_LOC;
      end
      S_LOC: begin
        cmd.loc   = 1'b1;
        state_nxt = S_FRD;
      end
      S_FRD: begin
        cmd.frd   = 1'b1;
        state_nxt = S_BUPD;
      end
      S_BUPD: begin
        if (stat.out_free) begin
          cmd.bin_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DRD: begin
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (stat.drain_empty) begin
          if (stat.out_free) begin
            cmd.empty_emit = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.drain_start = 1'b1;
          state_nxt       = S_ERD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (stat.out_free) begin
          cmd.drain_emit = 1'b1;
          state_nxt      = stat.drain_last ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/grid_block_binner_core.sv =====
// Top level of the grid block binner: controller, datapath and checks.
// Bin beat: the reciprocal divide, core test and bucket count read-modify-write run
//   through states DIV, LOC, FRD and BUPD before the result is registered.
// Drain beat: states DRD and DCHK read the bucket count, then each entry passes through
//   ERD and EOUT on the entry memory read port; an empty or out-of-grid block gives one beat.
// Synchronous reset clears control, mesh offsets and bucket count valid bits at once.
`default_nettype none
`include "grid_block_binner_core_defines.svh"

module grid_block_binner_core
  import gbb_pkg::*;
#(
  parameter int BLOCK_WIDTH    = 42,
  parameter int CORE_START     = 16,
  parameter int CORE_WIDTH     = 10,
  parameter int BLOCKS_PER_DIM = 8,
  parameter int BUCKET_DEPTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [OFS_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [IDX_W-1:0]      in_object_index,
  input  logic [PIX_W-1:0]      in_x_pixel,
  input  logic [PIX_W-1:0]      in_y_pixel,
  input  logic [ID_W-1:0]       in_drain_block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [ID_W-1:0]       out_blk_num,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [IDX_W-1:0]      out_found_index,
  output logic                  out_last
);

  gbb_cmd_t  cmd;
  gbb_stat_t stat;
  logic      beat_load;
  logic      drain_open;

  gbb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  gbb_datapath #(
    .BLOCK_WIDTH    (BLOCK_WIDTH),
    .CORE_START     (CORE_START),
    .CORE_WIDTH     (CORE_WIDTH),
    .BLOCKS_PER_DIM (BLOCKS_PER_DIM),
    .BUCKET_DEPTH   (BUCKET_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_object_index (in_object_index),
    .in_x_pixel      (in_x_pixel),
    .in_y_pixel      (in_y_pixel),
    .in_drain_block  (in_drain_block),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_blk_num     (out_blk_num),
    .out_slot        (out_slot),
    .out_found_index (out_found_index),
    .out_last        (out_last)
  );

  // Conditions watched by the checks below
  assign beat_load  = cmd.bin_commit | cmd.drain_emit | cmd.empty_emit;
  assign drain_open = out_valid && (out_status == ST_DRAINED) && !out_last;

  // A result beat is only loaded when the output register is free to take it
  `GBB_ASSERT_IMP(a_emit_when_free, beat_load, stat.out_free, "beat loaded over a held beat")

  // The controller issues at most one command per cycle
  `GBB_ASSERT_ALW(a_cmd_exclusive, $onehot0(cmd), "controller issued overlapping commands")

  // One request at a time: no new beat straight after an accepted one
  `GBB_ASSERT_NXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "request taken while busy")

  // A drain in progress keeps the input side closed
  `GBB_ASSERT_IMP(a_drain_blocks_input, drain_open, !in_ready, "input opened mid-drain")

endmodule

`default_nettype wire

// ===== tb/grid_block_binner_core_tb.sv =====
// Self-checking testbench for the grid block binner: directed table, then random rounds.
`timescale 1ns / 1ps

module grid_block_binner_core_tb;
  import gbb_pkg::*;

  // Geometry of the mesh, as built into the block by default
  localparam int BLOCK_WIDTH    = 42;
  localparam int CORE_START     = 16;
  localparam int CORE_WIDTH     = 10;
  localparam int BLOCKS_PER_DIM = 8;
  localparam int BUCKET_DEPTH   = 32;
  localparam int NUM_BLOCKS     = BLOCKS_PER_DIM * BLOCKS_PER_DIM;

  localparam int NUM_PHASES  = 10;
  localparam int ROUND_LEN   = 48;
  localparam int SETTLE_CYC  = 20;
  localparam int TAIL_CYC    = 80;
  localparam int NUM_DIRECTED = 22;

  // One request beat, with an optional hand-typed single result
  typedef struct packed {
    logic                  rt;
    logic [IDX_W-1:0]      obj;
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    logic [ID_W-1:0]       db;
    logic                  typed;
    status_t               st;
    logic [ID_W-1:0]       blk;
    logic [SLOT_OUT_W-1:0] slot;
    logic [IDX_W-1:0]      idx;
  } bin_request_t;

  // One result beat as the block should present it
  typedef struct packed {
    status_t               status;
    logic [ID_W-1:0]       blk_num;
    logic [SLOT_OUT_W-1:0] slot;
    logic [IDX_W-1:0]      found_index;
    logic                  last;
  } bin_result_t;

  // Directed requests; typed rows carry a result that is obvious from the geometry
  localparam bin_request_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd0,  1'b1, ST_EMPTY,   6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd16383, 9'd511, 9'd511, 6'd63, 1'b1, ST_EMPTY,   6'd63, 5'd0, 14'd0},
    '{1'b0, 14'd0,     9'd0,   9'd0,   6'd63, 1'b1, ST_OUTSIDE, 6'd0,  5'd0, 14'd0},
    '{1'b0, 14'd16383, 9'd511, 9'd511, 6'd0,  1'b1, ST_OUTSIDE, 6'd0,  5'd0, 14'd16383},
    '{1'b0, 14'd1,     9'd37,  9'd37,  6'd0,  1'b1, ST_BINNED,  6'd0,  5'd0, 14'd1},
    '{1'b0, 14'd16383, 9'd46,  9'd46,  6'd63, 1'b1, ST_BINNED,  6'd0,  5'd1, 14'd16383},
    '{1'b0, 14'd2,     9'd36,  9'd37,  6'd0,  1'b1, ST_OUTSIDE, 6'd0,  5'd0, 14'd2},
    '{1'b0, 14'd3,     9'd37,  9'd47,  6'd0,  1'b1, ST_OUTSIDE, 6'd0,  5'd0, 14'd3},
    '{1'b0, 14'd4,     9'd340, 9'd340, 6'd0,  1'b1, ST_BINNED,  6'd63, 5'd0, 14'd4},
    '{1'b0, 14'd5,     9'd373, 9'd37,  6'd0,  1'b1, ST_OUTSIDE, 6'd0,  5'd0, 14'd5},
    '{1'b0, 14'd6,     9'd79,  9'd37,  6'd0,  1'b1, ST_BINNED,  6'd8,  5'd0, 14'd6},
    '{1'b0, 14'd7,     9'd37,  9'd79,  6'd0,  1'b1, ST_BINNED,  6'd1,  5'd0, 14'd7},
    '{1'b0, 14'd10922, 9'd170, 9'd341, 6'd42, 1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b0, 14'd5461,  9'd341, 9'd170, 6'd21, 1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b0, 14'd9,     9'd361, 9'd205, 6'd0,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b0, 14'd11,    9'd46,  9'd37,  6'd0,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd0,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd0,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd63, 1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd8,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b0, 14'd12,    9'd37,  9'd37,  6'd1,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0},
    '{1'b1, 14'd0,     9'd0,   9'd0,   6'd0,  1'b0, ST_BINNED,  6'd0,  5'd0, 14'd0}
  };

  // Idling modes cycled through the random phases, and mesh offsets of the first five phases
  localparam int SEND_IDLE_PCT [0:3] = '{0, 69, 0, 7};
  localparam int RECV_STALL_PCT [0:3] = '{0, 0, 69, 7};
  localparam int FIXED_OFS_X [0:4] = '{-20, 20, -20, 20, 0};
  localparam int FIXED_OFS_Y [0:4] = '{20, -20, -20, 20, 0};

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_MESH_OFFSET_X;
  logic [OFS_W-1:0]      cfg_wdata       = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  in_req_type     = 1'b0;
  logic [IDX_W-1:0]      in_object_index = '0;
  logic [PIX_W-1:0]      in_x_pixel      = '0;
  logic [PIX_W-1:0]      in_y_pixel      = '0;
  logic [ID_W-1:0]       in_drain_block  = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [2:0]            out_status;
  logic [ID_W-1:0]       out_blk_num;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [IDX_W-1:0]      out_found_index;
  logic                  out_last;

  // Shadow of the block's buckets and offsets
  int                    mesh_ofs_x;
  int                    mesh_ofs_y;
  int                    bucket_count [NUM_BLOCKS];
  logic [IDX_W-1:0]      bucket_store [NUM_BLOCKS][BUCKET_DEPTH];
  bin_result_t           pending_results [$];

  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    mismatch_count;

  grid_block_binner_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_object_index (in_object_index),
    .in_x_pixel      (in_x_pixel),
    .in_y_pixel      (in_y_pixel),
    .in_drain_block  (in_drain_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_blk_num     (out_blk_num),
    .out_slot        (out_slot),
    .out_found_index (out_found_index),
    .out_last        (out_last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: ends a hung run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Finds the block along one axis; false when outside the grid or the core window.
  function automatic bit core_axis(input int pos, output int blk);
    int in_blk;
    blk = 0;
    if (pos < 0) return 1'b0;
    blk = pos / BLOCK_WIDTH;
    in_blk = pos - blk * BLOCK_WIDTH;
    return (blk < BLOCKS_PER_DIM) && (in_blk >= CORE_START) &&
           (in_blk < CORE_START + CORE_WIDTH);
  endfunction

  // A pixel coordinate that lands in the core of block b along one axis.
  function automatic logic [PIX_W-1:0] core_pixel(input int b, input int ofs);
    int p;
    p = ofs + BLOCK_WIDTH / 2 + b * BLOCK_WIDTH +
        $urandom_range(CORE_START, CORE_START + CORE_WIDTH - 1);
    return p[PIX_W-1:0];
  endfunction

  function automatic void queue_result(input status_t st, input int blk, input int slot,
                                       input logic [IDX_W-1:0] idx, input logic last);
    bin_result_t r;
    r.status      = st;
    r.blk_num     = blk[ID_W-1:0];
    r.slot        = slot[SLOT_OUT_W-1:0];
    r.found_index = idx;
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  // Updates the bucket shadow for one accepted beat and, if asked, queues its results.
  function automatic void predict_request(input bin_request_t b, input bit keep);
    int  px, py, bx, by, blk, n;
    bit  hit_x, hit_y;
    if (b.rt == 1'b0) begin
      px = int'(b.x) - mesh_ofs_x - BLOCK_WIDTH / 2;
      py = int'(b.y) - mesh_ofs_y - BLOCK_WIDTH / 2;
      hit_x = core_axis(px, bx);
      hit_y = core_axis(py, by);
      if (!(hit_x && hit_y)) begin
        if (keep) queue_result(ST_OUTSIDE, 0, 0, b.obj, 1'b1);
      end else begin
        blk = bx * BLOCKS_PER_DIM + by;
        if (bucket_count[blk] >= BUCKET_DEPTH) begin
          if (keep) queue_result(ST_FULL, blk, 0, b.obj, 1'b1);
        end else begin
          bucket_store[blk][bucket_count[blk]] = b.obj;
          if (keep) queue_result(ST_BINNED, blk, bucket_count[blk], b.obj, 1'b1);
          bucket_count[blk]++;
        end
      end
    end else begin
      blk = int'(b.db);
      if (blk >= NUM_BLOCKS || bucket_count[blk] == 0) begin
        if (keep) queue_result(ST_EMPTY, blk, 0, '0, 1'b1);
      end else begin
        n = bucket_count[blk];
        for (int k = 0; k < n; k++) begin
          if (keep) queue_result(ST_DRAINED, blk, k, bucket_store[blk][k], k + 1 == n);
        end
        bucket_count[blk] = 0;
      end
    end
  endfunction

  // Presents one request beat, waits for its acceptance, then idles at random.
  task automatic send_beat(input bin_request_t b);
    in_valid        <= 1'b1;
    in_req_type     <= b.rt;
    in_object_index <= b.obj;
    in_x_pixel      <= b.x;
    in_y_pixel      <= b.y;
    in_drain_block  <= b.db;
    do @(posedge clk); while (!in_ready);
    predict_request(b, !b.typed);
    if (b.typed) queue_result(b.st, int'(b.blk), int'(b.slot), b.idx, 1'b1);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Writes both offsets once every outstanding result has come back.
  task automatic set_mesh_offsets(input int ox, input int oy);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MESH_OFFSET_X;
    cfg_wdata <= ox[OFS_W-1:0];
    @(posedge clk);
    cfg_index <= REG_MESH_OFFSET_Y;
    cfg_wdata <= oy[OFS_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    mesh_ofs_x = ox;
    mesh_ofs_y = oy;
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with none expected: status %0d block %0d slot %0d index %0d",
               out_status, out_blk_num, out_slot, out_found_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_blk_num !== want.blk_num) begin
          $error("blk_num: expected %0d, got %0d", want.blk_num, out_blk_num);
          mismatch_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          mismatch_count++;
        end
        if (out_found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_found_index);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then rounds that each fill one hot block.
  initial begin
    bin_request_t req;
    int           hot_bx, hot_by, pick, ox, oy;
    mismatch_count = 0;
    mesh_ofs_x     = 0;
    mesh_ofs_y     = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    for (int b = 0; b < NUM_BLOCKS; b++) bucket_count[b] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset offsets
    for (int r = 0; r < NUM_DIRECTED; r++) send_beat(DIRECTED_ROWS[r]);
    in_valid <= 1'b0;

    // Random part: one offset setting and idling mode per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph % 4];
      recv_stall_pct = RECV_STALL_PCT[ph % 4];
      if (ph < 5) begin
        ox = FIXED_OFS_X[ph];
        oy = FIXED_OFS_Y[ph];
      end else begin
        ox = $urandom_range(0, 40) - 20;
        oy = $urandom_range(0, 40) - 20;
      end
      set_mesh_offsets(ox, oy);
      hot_bx = $urandom_range(0, BLOCKS_PER_DIM - 1);
      hot_by = $urandom_range(0, BLOCKS_PER_DIM - 1);
      for (int i = 0; i < ROUND_LEN; i++) begin
        req       = '0;
        req.obj   = IDX_W'($urandom_range(0, 16383));
        req.x     = PIX_W'($urandom_range(0, 511));
        req.y     = PIX_W'($urandom_range(0, 511));
        req.db    = ID_W'($urandom_range(0, NUM_BLOCKS - 1));
        pick      = $urandom_range(99);
        // Mostly core hits on the hot block so that its bucket overflows
        if (pick < 74) begin
          req.x = core_pixel(hot_bx, mesh_ofs_x);
          req.y = core_pixel(hot_by, mesh_ofs_y);
        end else if (pick < 84) begin
          req.x = core_pixel($urandom_range(0, BLOCKS_PER_DIM - 1), mesh_ofs_x);
          req.y = core_pixel($urandom_range(0, BLOCKS_PER_DIM - 1), mesh_ofs_y);
        end else if (pick >= 92) begin
          req.rt = 1'b1;
        end
        send_beat(req);
      end
      // Close the round by draining the hot block
      req    = '0;
      req.rt = 1'b1;
      req.obj = IDX_W'($urandom_range(0, 16383));
      req.db = ID_W'(hot_bx * BLOCKS_PER_DIM + hot_by);
      send_beat(req);
      in_valid <= 1'b0;
    end

    // Let the last results drain out, then a short quiet tail
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== grid_block_binner_core.f =====
+incdir+hw/rtl
hw/rtl/gbb_pkg.sv
hw/rtl/gbb_axis.sv
hw/rtl/gbb_datapath.sv
hw/rtl/gbb_ctrl.sv
hw/rtl/grid_block_binner_core.sv
tb/grid_block_binner_core_tb.sv
